// ----- design/ppp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packed pixel plot unit package
// Shared types, codes and reset constants for the 4bpp framebuffer block.
// ----------------------------------------------------------------------------
package ppp_pkg;

  typedef enum logic [1:0] {
    CMD_PLOT  = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_CAMERA_X    = 3'd0,
    CFG_CAMERA_Y    = 3'd1,
    CFG_CLIP_LEFT   = 3'd2,
    CFG_CLIP_TOP    = 3'd3,
    CFG_CLIP_RIGHT  = 3'd4,
    CFG_CLIP_BOTTOM = 3'd5,
    CFG_PALETTE     = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACT
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0]         pen_color;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pixel_value;
    logic       on_screen;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // request accepted this cycle
    logic sweep_init;  // start a fill sweep with the request colour
    logic sweep;       // write one fill byte
    logic commit;      // finish the held plot or get
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_busy;
    cmd_e cmd;
  } stat_t;

  localparam logic [15:0] CAMERA_RESET      = 16'd0;
  localparam logic [7:0]  CLIP_LEFT_RESET   = 8'd0;
  localparam logic [7:0]  CLIP_TOP_RESET    = 8'd0;
  localparam logic [7:0]  CLIP_RIGHT_RESET  = 8'd128;
  localparam logic [7:0]  CLIP_BOTTOM_RESET = 8'd128;
  localparam logic [63:0] PALETTE_RESET     = 64'hFEDC_BA98_7654_3210;

endpackage : ppp_pkg
`default_nettype wire

// ----- design/ppp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packed pixel plot controller
// Sequences fill sweeps, request intake and the read-modify-write step.
// ----------------------------------------------------------------------------
module ppp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire ppp_pkg::cmd_e in_cmd_i,
  output logic               in_ready_o,
  input  wire ppp_pkg::stat_t stat_i,
  output ppp_pkg::ctrl_t     ctrl_o
);

  ppp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    case (state_q)
      ppp_pkg::ST_CLEAR: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ppp_pkg::ST_IDLE;
        end
      end
      ppp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.take = 1'b1;
          case (in_cmd_i)
            ppp_pkg::CMD_CLEAR: begin
              ctrl_o.sweep_init = 1'b1;
              state_d           = ppp_pkg::ST_CLEAR;
            end
            ppp_pkg::CMD_PLOT, ppp_pkg::CMD_GET: begin
              state_d = ppp_pkg::ST_ACT;
            end
            default: begin
              state_d = ppp_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ppp_pkg::ST_ACT: begin
        if (!(stat_i.cmd == ppp_pkg::CMD_GET && stat_i.out_busy)) begin
          ctrl_o.commit = 1'b1;
          state_d       = ppp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule : ppp_ctrl
`default_nettype wire

// ----- design/ppp_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packed pixel plot datapath
// Registers, address and clip logic, frame memory and result register.
// ----------------------------------------------------------------------------
module ppp_dp #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire ppp_pkg::cfg_idx_e  cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire ppp_pkg::in_item_t  in_item_i,
  input  wire ppp_pkg::ctrl_t     ctrl_i,
  output ppp_pkg::stat_t          stat_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output ppp_pkg::out_item_t      out_item_o
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int DEPTH  = (PIXELS + 1) / 2;
  localparam int PW     = $clog2(PIXELS);
  localparam int AW     = PW - 1;
  localparam int XW     = $clog2(SCREEN_WIDTH);
  localparam int YW     = $clog2(SCREEN_HEIGHT);
  localparam logic signed [16:0] WIDTH_S  = 17'(SCREEN_WIDTH);
  localparam logic signed [16:0] HEIGHT_S = 17'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [PW-1:0]      WIDTH_P   = PW'(SCREEN_WIDTH);

  logic [15:0] camera_x_q, camera_y_q;
  logic [7:0]  clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [63:0] palette_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_x_q    <= ppp_pkg::CAMERA_RESET;
      camera_y_q    <= ppp_pkg::CAMERA_RESET;
      clip_left_q   <= ppp_pkg::CLIP_LEFT_RESET;
      clip_top_q    <= ppp_pkg::CLIP_TOP_RESET;
      clip_right_q  <= ppp_pkg::CLIP_RIGHT_RESET;
      clip_bottom_q <= ppp_pkg::CLIP_BOTTOM_RESET;
      palette_q     <= ppp_pkg::PALETTE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ppp_pkg::CFG_CAMERA_X:    camera_x_q    <= cfg_data_i[15:0];
        ppp_pkg::CFG_CAMERA_Y:    camera_y_q    <= cfg_data_i[15:0];
        ppp_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i[7:0];
        ppp_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i[7:0];
        ppp_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_data_i[7:0];
        ppp_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data_i[7:0];
        ppp_pkg::CFG_PALETTE:     palette_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // address and window tests on the incoming request
  logic               is_plot;
  logic signed [15:0] x_w, y_w;
  logic signed [16:0] x_s, y_s;
  logic               on_scr, clip_ok, hit_d;
  logic [PW-1:0]      pix;
  logic [3:0]         mapped;

  always_comb begin
    is_plot = (in_item_i.cmd == ppp_pkg::CMD_PLOT);
    x_w     = is_plot ? in_item_i.pos_x - $signed(camera_x_q) : in_item_i.pos_x;
    y_w     = is_plot ? in_item_i.pos_y - $signed(camera_y_q) : in_item_i.pos_y;
    x_s     = 17'(x_w);
    y_s     = 17'(y_w);
    on_scr  = (x_s >= 17'sd0) && (x_s < WIDTH_S) && (y_s >= 17'sd0) && (y_s < HEIGHT_S);
    clip_ok = (x_s >= $signed({9'd0, clip_left_q})) && (x_s < $signed({9'd0, clip_right_q}))
           && (y_s >= $signed({9'd0, clip_top_q})) && (y_s < $signed({9'd0, clip_bottom_q}));
    hit_d   = on_scr && (!is_plot || clip_ok);
    pix     = PW'(PW'(y_w[YW-1:0]) * WIDTH_P) + PW'(x_w[XW-1:0]);
    mapped  = palette_q[{in_item_i.pen_color, 2'b00} +: 4];
  end

  ppp_pkg::cmd_e  cmd_q;
  logic [AW-1:0]  addr_q;
  logic           nib_q, hit_q;
  logic [3:0]     colour_q;
  logic [7:0]     rd_data_q;
  logic [AW-1:0]  cnt_q;
  logic [7:0]     fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= ppp_pkg::CMD_NONE;
      hit_q  <= 1'b0;
      cnt_q  <= '0;
      fill_q <= 8'h00;
    end else begin
      if (ctrl_i.take) begin
        cmd_q <= in_item_i.cmd;
        hit_q <= hit_d;
      end
      if (ctrl_i.sweep_init) begin
        cnt_q  <= '0;
        fill_q <= {in_item_i.pen_color, in_item_i.pen_color};
      end else if (ctrl_i.sweep) begin
        cnt_q <= (cnt_q == LAST_ADDR) ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      addr_q   <= pix[PW-1:1];
      nib_q    <= pix[0];
      colour_q <= mapped;
    end
  end

  // frame memory
  logic [7:0]    mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = nib_q ? {colour_q, rd_data_q[3:0]} : {rd_data_q[7:4], colour_q};
    if (ctrl_i.sweep) begin
      mem_we = 1'b1;
      mem_wa = cnt_q;
      mem_wd = fill_q;
    end else if (ctrl_i.commit && cmd_q == ppp_pkg::CMD_PLOT && hit_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctrl_i.take) begin
      rd_data_q <= mem[pix[PW-1:1]];
    end
  end

  // result register
  logic               out_valid_q;
  ppp_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit && cmd_q == ppp_pkg::CMD_GET) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && cmd_q == ppp_pkg::CMD_GET) begin
      out_q.pixel_value <= !hit_q ? 4'h0 : (nib_q ? rd_data_q[7:4] : rd_data_q[3:0]);
      out_q.on_screen   <= hit_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;
  assign stat_o.sweep_last = (cnt_q == LAST_ADDR);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;
  assign stat_o.cmd        = cmd_q;

endmodule : ppp_dp
`default_nettype wire

// ----- design/packed_pixel_plot_unit_top.sv -----
`default_nettype none
// Plot and get each accept the request, then do the memory read-modify-write;
// a get result is registered in the read-modify-write step, and the next request
// is taken back in idle; a get stalls while the previous result is unread.
// A clear sweeps one byte a cycle through the frame memory after its intake.
// After reset the same sweep zeroes the memory; in_ready_o stays low for it.
// ----------------------------------------------------------------------------
// Packed pixel plot unit
// 4bpp packed framebuffer with camera, clip window, palette and clear.
// ----------------------------------------------------------------------------
module packed_pixel_plot_unit_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire ppp_pkg::cfg_idx_e  cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ppp_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ppp_pkg::out_item_t      out_item_o
);

  ppp_pkg::ctrl_t ctrl;
  ppp_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  ppp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ppp_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule : packed_pixel_plot_unit_top
`default_nettype wire

// ----- tb/sv/ppp_frame_checker.sv -----
// ----------------------------------------------------------------------------
// Packed pixel plot unit: frame checker
// Watches the register, request and result channels of the block. It keeps
// its own copy of the registers and the packed 4bpp frame, works out the
// result of every get request, and compares each returned result, field by
// field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module ppp_frame_checker #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  ppp_pkg::cfg_idx_e  cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  ppp_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  ppp_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;

  logic signed [15:0] cam_x;
  logic signed [15:0] cam_y;
  logic [7:0]         clip_l;
  logic [7:0]         clip_t;
  logic [7:0]         clip_r;
  logic [7:0]         clip_b;
  logic [63:0]        palette;
  logic [7:0]         frame [FRAME_BYTES];
  ppp_pkg::out_item_t owed_reads [$];

  function automatic bit visible(int x, int y);
    return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
  endfunction

  task automatic apply_request(ppp_pkg::in_item_t req);
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    int                 x;
    int                 y;
    int                 p;
    logic [3:0]         colour;
    ppp_pkg::out_item_t res;
    case (req.cmd)
      ppp_pkg::CMD_PLOT: begin
        dx     = req.pos_x - cam_x;
        dy     = req.pos_y - cam_y;
        x      = dx;
        y      = dy;
        colour = palette[4*req.pen_color +: 4];
        if (x >= int'(clip_l) && y >= int'(clip_t) && x < int'(clip_r) &&
            y < int'(clip_b) && visible(x, y)) begin
          p = y * SCREEN_WIDTH + x;
          if (p[0]) begin
            frame[p >> 1][7:4] = colour;
          end else begin
            frame[p >> 1][3:0] = colour;
          end
        end
      end
      ppp_pkg::CMD_GET: begin
        x   = req.pos_x;
        y   = req.pos_y;
        res = '0;
        if (visible(x, y)) begin
          p               = y * SCREEN_WIDTH + x;
          res.pixel_value = p[0] ? frame[p >> 1][7:4] : frame[p >> 1][3:0];
          res.on_screen   = 1'b1;
        end
        owed_reads.push_back(res);
      end
      ppp_pkg::CMD_CLEAR: begin
        foreach (frame[i]) frame[i] = {2{req.pen_color}};
      end
      default: ;
    endcase
  endtask

  task automatic check_read(ppp_pkg::out_item_t got);
    ppp_pkg::out_item_t want;
    if (owed_reads.size() == 0) begin
      $error("unexpected read result: pixel_value %0d on_screen %0d",
             got.pixel_value, got.on_screen);
      fail_count_o++;
      return;
    end
    want = owed_reads.pop_front();
    if (got.pixel_value !== want.pixel_value) begin
      $error("pixel_value: expected %0d, got %0d", want.pixel_value, got.pixel_value);
      fail_count_o++;
    end
    if (got.on_screen !== want.on_screen) begin
      $error("on_screen: expected %0d, got %0d", want.on_screen, got.on_screen);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x   = ppp_pkg::CAMERA_RESET;
      cam_y   = ppp_pkg::CAMERA_RESET;
      clip_l  = ppp_pkg::CLIP_LEFT_RESET;
      clip_t  = ppp_pkg::CLIP_TOP_RESET;
      clip_r  = ppp_pkg::CLIP_RIGHT_RESET;
      clip_b  = ppp_pkg::CLIP_BOTTOM_RESET;
      palette = ppp_pkg::PALETTE_RESET;
      foreach (frame[i]) frame[i] = 8'h00;
      owed_reads.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_read(out_item_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ppp_pkg::CFG_CAMERA_X:    cam_x   = cfg_data_i[15:0];
          ppp_pkg::CFG_CAMERA_Y:    cam_y   = cfg_data_i[15:0];
          ppp_pkg::CFG_CLIP_LEFT:   clip_l  = cfg_data_i[7:0];
          ppp_pkg::CFG_CLIP_TOP:    clip_t  = cfg_data_i[7:0];
          ppp_pkg::CFG_CLIP_RIGHT:  clip_r  = cfg_data_i[7:0];
          ppp_pkg::CFG_CLIP_BOTTOM: clip_b  = cfg_data_i[7:0];
          ppp_pkg::CFG_PALETTE:     palette = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) apply_request(in_item_i);
      pending_o = owed_reads.size();
    end
  end

endmodule

// ----- tb/sv/packed_pixel_plot_unit_top_test.sv -----
// ----------------------------------------------------------------------------
// Packed pixel plot unit testbench
// Directed plot, get and clear requests at the screen edges, then phases of
// random requests, each under its own camera, clip window and palette, with
// random gaps on the request side and random stalls on the result side but
// in one calm phase. Checking is done by the frame checker beside the block.
// ----------------------------------------------------------------------------
module packed_pixel_plot_unit_top_test;

  localparam int SWEEP_CYCLES = 8300;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 145;
  localparam int LIMIT_TIME   = 20_000_000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  ppp_pkg::cfg_idx_e  cfg_index_i = ppp_pkg::CFG_CAMERA_X;
  logic [63:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  ppp_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  ppp_pkg::out_item_t out_item_o;
  int                 fail_count;
  int                 pending;
  logic               calm        = 1'b0;
  logic [15:0]        cam_x_now   = '0;
  logic [15:0]        cam_y_now   = '0;
  logic [15:0]        last_x      = '0;
  logic [15:0]        last_y      = '0;

  always #5 clk_i = ~clk_i;

  packed_pixel_plot_unit_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  ppp_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 32);
  end

  initial begin
    #(LIMIT_TIME);
    $display("packed_pixel_plot_unit_top_test failed");
    $finish;
  end

  function automatic ppp_pkg::in_item_t make_request(ppp_pkg::cmd_e c, int x, int y, int pen);
    ppp_pkg::in_item_t req;
    req.cmd       = c;
    req.pos_x     = 16'(x);
    req.pos_y     = 16'(y);
    req.pen_color = 4'(pen);
    return req;
  endfunction

  // mostly on screen, some just past the edges, a few anywhere
  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(127));
    if (r < 85) return 16'($urandom_range(135)) - 16'd4;
    return 16'($urandom);
  endfunction

  task automatic push_request(ppp_pkg::in_item_t req);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(ppp_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // all reads back, then room for a clear sweep still running
  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    repeat (SWEEP_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(int ph);
    logic [15:0] cx;
    logic [15:0] cy;
    logic [7:0]  l;
    logic [7:0]  t;
    logic [7:0]  r;
    logic [7:0]  b;
    logic [63:0] pal;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    pal  = {$urandom, $urandom};
    cx   = 16'h0000;
    cy   = 16'h0000;
    l    = 8'd0;
    t    = 8'd0;
    r    = 8'd128;
    b    = 8'd128;
    case (ph)
      2: begin
        cx  = 16'h7FFF;
        cy  = 16'h8000;
        r   = 8'd255;
        b   = 8'd255;
        pal = '1;
      end
      3: begin
        cx = 16'($urandom_range(40)) - 16'd20;
        cy = 16'($urandom_range(40)) - 16'd20;
        l  = 8'($urandom_range(100));
        t  = 8'($urandom_range(100));
        r  = l + 8'd1 + 8'($urandom_range(127 - l));
        b  = t + 8'd1 + 8'($urandom_range(127 - t));
      end
      4: begin
        cx  = 16'($urandom);
        cy  = 16'($urandom);
        l   = 8'd255;
        t   = 8'd255;
        r   = 8'd0;
        b   = 8'd0;
        pal = '0;
      end
      5: begin
        cx = 16'($urandom_range(128)) - 16'd64;
        cy = 16'($urandom_range(128)) - 16'd64;
        l  = 8'($urandom_range(255));
        t  = 8'($urandom_range(255));
        r  = 8'($urandom_range(255));
        b  = 8'($urandom_range(255));
      end
      6: begin
        cx = 16'h8000;
        cy = 16'h7FFF;
      end
      7: begin
        cx = 16'($urandom_range(16)) - 16'd8;
        cy = 16'($urandom_range(16)) - 16'd8;
        l  = 8'($urandom_range(128));
        t  = 8'($urandom_range(128));
        r  = 8'($urandom_range(128));
        b  = 8'($urandom_range(128));
        write_reg(ppp_pkg::CFG_UNUSED, junk ^ {$urandom, $urandom});
      end
      8: pal = ppp_pkg::PALETTE_RESET;
      default: ;
    endcase
    write_reg(ppp_pkg::CFG_CAMERA_X,    {junk[63:16], cx});
    write_reg(ppp_pkg::CFG_CAMERA_Y,    {junk[47:0], cy});
    write_reg(ppp_pkg::CFG_CLIP_LEFT,   {junk[63:8], l});
    write_reg(ppp_pkg::CFG_CLIP_TOP,    {~junk[55:0], t});
    write_reg(ppp_pkg::CFG_CLIP_RIGHT,  {junk[55:0], r});
    write_reg(ppp_pkg::CFG_CLIP_BOTTOM, {~junk[63:8], b});
    write_reg(ppp_pkg::CFG_PALETTE,     pal);
    cfg_valid_i <= 1'b0;
    cam_x_now = cx;
    cam_y_now = cy;
  endtask

  task automatic random_request(output ppp_pkg::in_item_t req);
    int          r;
    logic [15:0] sx;
    logic [15:0] sy;
    r   = $urandom_range(999);
    req = make_request(ppp_pkg::CMD_NONE, $urandom, $urandom, $urandom);
    if (r < 10) begin
      req.cmd = ppp_pkg::CMD_CLEAR;
    end else if (r < 540) begin
      sx        = pick_coord();
      sy        = pick_coord();
      last_x    = sx;
      last_y    = sy;
      req.cmd   = ppp_pkg::CMD_PLOT;
      req.pos_x = sx + cam_x_now;
      req.pos_y = sy + cam_y_now;
    end else if (r >= 570) begin
      req.cmd = ppp_pkg::CMD_GET;
      if ($urandom_range(1)) begin
        req.pos_x = last_x;
        req.pos_y = last_y;
      end else begin
        req.pos_x = pick_coord();
        req.pos_y = pick_coord();
      end
    end
  endtask

  initial begin
    ppp_pkg::in_item_t req;
    int                n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_request(make_request(ppp_pkg::CMD_GET, 0, 0, 0));
    push_request(make_request(ppp_pkg::CMD_PLOT, 0, 0, 15));
    push_request(make_request(ppp_pkg::CMD_GET, 0, 0, 0));
    push_request(make_request(ppp_pkg::CMD_PLOT, 1, 0, 5));
    push_request(make_request(ppp_pkg::CMD_GET, 1, 0, 0));
    push_request(make_request(ppp_pkg::CMD_GET, 0, 0, 0));
    push_request(make_request(ppp_pkg::CMD_PLOT, 127, 127, 10));
    push_request(make_request(ppp_pkg::CMD_GET, 127, 127, 0));
    push_request(make_request(ppp_pkg::CMD_PLOT, 128, 0, 7));
    push_request(make_request(ppp_pkg::CMD_GET, 128, 0, 0));
    push_request(make_request(ppp_pkg::CMD_PLOT, -1, 5, 3));
    push_request(make_request(ppp_pkg::CMD_GET, -1, 5, 0));
    push_request(make_request(ppp_pkg::CMD_GET, -32768, 32767, 0));
    push_request(make_request(ppp_pkg::CMD_GET, 32767, -32768, 0));
    push_request(make_request(ppp_pkg::CMD_NONE, $urandom, $urandom, $urandom));
    push_request(make_request(ppp_pkg::CMD_GET, 127, 0, 0));
    push_request(make_request(ppp_pkg::CMD_CLEAR, 0, 0, 9));
    push_request(make_request(ppp_pkg::CMD_GET, 0, 0, 0));
    push_request(make_request(ppp_pkg::CMD_GET, 127, 127, 0));
    push_request(make_request(ppp_pkg::CMD_PLOT, 3, 3, 0));
    push_request(make_request(ppp_pkg::CMD_GET, 3, 3, 0));
    push_request(make_request(ppp_pkg::CMD_GET, 2, 3, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        in_valid_i <= 1'b0;
        drain();
        load_settings(ph);
      end
      calm <= (ph == 3);
      n = 0;
      while (n < PHASE_ITEMS) begin
        random_request(req);
        push_request(req);
        if (req.cmd != ppp_pkg::CMD_NONE) n++;
      end
    end
    in_valid_i <= 1'b0;
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("packed_pixel_plot_unit_top_test passed");
    end else begin
      $display("packed_pixel_plot_unit_top_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ppp_pkg.sv
design/ppp_ctrl.sv
design/ppp_dp.sv
design/packed_pixel_plot_unit_top.sv
tb/sv/ppp_frame_checker.sv
tb/sv/packed_pixel_plot_unit_top_test.sv
